// File: design/matrix_multiply_top_assert.svh
// ----------------------------------------------------------------------------
// Matrix multiply assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define MATRIX_MULTIPLY_TOP_ASSERT_SVH

// same-cycle implication
`define MM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared widths, register indexes, item modes, state and command types.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    localparam int DIM_W     = 4;
    localparam int IDX_W     = 3;
    localparam int DOT_W     = 35;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [DIM_W-1:0]     t_dim;
    typedef logic [IDX_W-1:0]     t_idx;

    localparam t_mode MODE_LOAD_LEFT  = 2'd0;
    localparam t_mode MODE_LOAD_RIGHT = 2'd1;
    localparam t_mode MODE_START      = 2'd2;

    localparam t_cfg_idx CFG_ROWS_A    = 2'd0;
    localparam t_cfg_idx CFG_INNER_DIM = 2'd1;
    localparam t_cfg_idx CFG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_WAIT_OUT
    } t_state;

    typedef struct packed {
        logic wr_left;
        logic wr_right;
        t_idx wr_row;
        t_idx wr_col;
        logic issue;
        logic first;
        logic lastk;
        t_idx rd_row;
        t_idx rd_col;
        t_idx rd_k;
        logic load_out;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic acc_done;
        logic out_free;
    } t_status;

    function automatic t_dim clamp_dim(input t_dim v, input int max_dim);
        t_dim res;
        res = v;
        if (v == '0) begin
            res = t_dim'(1);
        end else if (int'(v) > max_dim) begin
            res = t_dim'(max_dim);
        end
        return res;
    endfunction

endpackage

// File: design/mm_in_if.sv
// ----------------------------------------------------------------------------
// Matrix multiply input channel
// Load and start items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm_in_if
    import mm_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [MODE_W-1:0]            mode;
    logic [IDX_W-1:0]             row_index;
    logic [IDX_W-1:0]             col_index;
    logic signed [ELEM_WIDTH-1:0] element;

    modport source (output valid, mode, row_index, col_index, element, input ready);
    modport sink   (input valid, mode, row_index, col_index, element, output ready);
endinterface

// File: design/mm_out_if.sv
// ----------------------------------------------------------------------------
// Matrix multiply output channel
// Result items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm_out_if
    import mm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [DOT_W-1:0] dot_value;
    logic                    last;

    modport source (output valid, out_row, out_col, dot_value, last, input ready);
    modport sink   (input valid, out_row, out_col, dot_value, last, output ready);
endinterface

// File: design/mm_ram.sv
// ----------------------------------------------------------------------------
// Matrix multiply RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/mm_datapath.sv
// ----------------------------------------------------------------------------
// Matrix multiply datapath
// Element stores, multiply stage, accumulator and result register.
// ----------------------------------------------------------------------------
module mm_datapath
    import mm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [ELEM_WIDTH-1:0] i_element,
    input  t_cmd                         i_cmd,
    output t_status                      o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [IDX_W-1:0]             o_out_row,
    output logic [IDX_W-1:0]             o_out_col,
    output logic signed [DOT_W-1:0]      o_dot_value,
    output logic                         o_last
);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic [AW-1:0]                w_addr;
    logic [AW-1:0]                left_raddr;
    logic [AW-1:0]                right_raddr;
    logic [ELEM_WIDTH-1:0]        left_rdata;
    logic [ELEM_WIDTH-1:0]        right_rdata;
    logic signed [PROD_W-1:0]     n_prod;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [DOT_W-1:0]      prod_ext;
    logic [DOT_W-1:0]             r_acc;
    logic                         r_s1_valid, r_s1_first, r_s1_lastk;
    logic                         r_s2_valid, r_s2_first, r_s2_lastk;
    logic                         r_acc_done;
    logic                         r_out_valid;
    logic [IDX_W-1:0]             r_out_row, r_out_col;
    logic [DOT_W-1:0]             r_out_dot;
    logic                         r_out_last;

    assign w_addr      = AW'(int'(i_cmd.wr_row) * MAX_DIM + int'(i_cmd.wr_col));
    assign left_raddr  = AW'(int'(i_cmd.rd_row) * MAX_DIM + int'(i_cmd.rd_k));
    assign right_raddr = AW'(int'(i_cmd.rd_k) * MAX_DIM + int'(i_cmd.rd_col));

    mm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_left),
        .i_waddr (w_addr),
        .i_wdata (i_element),
        .i_raddr (left_raddr),
        .o_rdata (left_rdata)
    );

    mm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_right),
        .i_waddr (w_addr),
        .i_wdata (i_element),
        .i_raddr (right_raddr),
        .o_rdata (right_rdata)
    );

    assign n_prod = signed'(left_rdata) * signed'(right_rdata);

    generate
        if (PROD_W >= DOT_W) begin : g_prod_trunc
            assign prod_ext = r_prod[DOT_W-1:0];
        end else begin : g_prod_sext
            assign prod_ext = DOT_W'(r_prod);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            r_acc_done <= r_s2_valid & r_s2_lastk;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.first;
        r_s1_lastk <= i_cmd.lastk;
        r_s2_first <= r_s1_first;
        r_s2_lastk <= r_s1_lastk;
        r_prod     <= n_prod;
        if (r_s2_valid) begin
            r_acc <= r_s2_first ? prod_ext : r_acc + prod_ext;
        end
        if (i_cmd.load_out) begin
            r_out_row  <= i_cmd.rd_row;
            r_out_col  <= i_cmd.rd_col;
            r_out_dot  <= r_acc;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.acc_done = r_acc_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_dot_value    = signed'(r_out_dot);
    assign o_last         = r_out_last;
endmodule

// File: design/mm_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix multiply controller
// Configuration registers and the load / multiply sequencing FSM.
// ----------------------------------------------------------------------------
module mm_ctrl
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  t_cfg_idx       i_cfg_idx,
    input  t_dim           i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  t_mode          i_mode,
    input  t_idx           i_row_index,
    input  t_idx           i_col_index,
    input  t_status        i_sts,
    output t_cmd           o_cmd
);
`include "matrix_multiply_top_assert.svh"

    t_state r_state, n_state;
    t_dim   r_rows_a, r_inner_dim, r_cols_b;
    t_idx   r_r, n_r, r_c, n_c, r_k, n_k;
    t_dim   nr, nk, nc;
    logic   in_accept;
    logic   idx_ok;
    logic   last_r, last_c, last_k;

    assign nr = clamp_dim(r_rows_a, MAX_DIM);
    assign nk = clamp_dim(r_inner_dim, MAX_DIM);
    assign nc = clamp_dim(r_cols_b, MAX_DIM);

    assign last_r = ({1'b0, r_r} == nr - t_dim'(1));
    assign last_c = ({1'b0, r_c} == nc - t_dim'(1));
    assign last_k = ({1'b0, r_k} == nk - t_dim'(1));

    assign in_accept = i_in_valid && o_in_ready;
    assign idx_ok    = (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_RESET;
            r_inner_dim <= DIM_RESET;
            r_cols_b    <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_r     <= n_r;
            r_c     <= n_c;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_r            = r_r;
        n_c            = r_c;
        n_k            = r_k;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.wr_row   = i_row_index;
        o_cmd.wr_col   = i_col_index;
        o_cmd.rd_row   = r_r;
        o_cmd.rd_col   = r_c;
        o_cmd.rd_k     = r_k;
        o_cmd.first    = (r_k == '0);
        o_cmd.lastk    = last_k;
        o_cmd.out_last = last_r && last_c;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_accept) begin
                    unique case (i_mode)
                        MODE_LOAD_LEFT:  o_cmd.wr_left  = idx_ok;
                        MODE_LOAD_RIGHT: o_cmd.wr_right = idx_ok;
                        MODE_START: begin
                            n_state = S_ISSUE;
                            n_r     = '0;
                            n_c     = '0;
                            n_k     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (last_k) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + t_idx'(1);
                end
            end
            S_DRAIN: begin
                if (i_sts.acc_done) begin
                    n_state = S_WAIT_OUT;
                end
            end
            S_WAIT_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (last_c) begin
                        n_c = '0;
                        if (last_r) begin
                            n_state = S_IDLE;
                        end else begin
                            n_r     = r_r + t_idx'(1);
                            n_state = S_ISSUE;
                        end
                    end else begin
                        n_c     = r_c + t_idx'(1);
                        n_state = S_ISSUE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `MM_ASSERT_NOW(a_done_in_drain, i_clk, i_rst_n, i_sts.acc_done, r_state == S_DRAIN, "accumulator done outside drain")
    `MM_ASSERT_NEXT(a_lastk_to_drain, i_clk, i_rst_n, o_cmd.issue && o_cmd.lastk, r_state == S_DRAIN, "last step not followed by drain")
    `MM_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free, "result loaded over a pending item")
endmodule

// File: design/matrix_multiply_top.sv
// A load item is accepted whenever the engine is idle, one per cycle back to back. After a
// start item is accepted, each result is formed by one multiply-accumulate per cycle over the
// clamped inner_dim, through a single read port per element store, then passes the element
// store read register, product register and accumulator, and is loaded into the result
// register once it is free; input is held off until the last result is registered.
// Synchronous active-low reset restores dimensions to 8; element stores are not cleared.
// ----------------------------------------------------------------------------
// Matrix multiply top level
// Dense fixed-point matrix multiply engine with element stores and one MAC.
// ----------------------------------------------------------------------------
module matrix_multiply_top
    import mm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mm_in_if.sink                i_in,
    mm_out_if.source             o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);
    t_cmd    cmd;
    t_status sts;

    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_mode      (i_in.mode),
        .i_row_index (i_in.row_index),
        .i_col_index (i_in.col_index),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_element   (i_in.element),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_row   (o_out.out_row),
        .o_out_col   (o_out.out_col),
        .o_dot_value (o_out.dot_value),
        .o_last      (o_out.last)
    );
endmodule
